[design/sensor_window_normalizer_assert.svh]
// Assertion macros shared by the checker of the sensor window normaliser
`ifndef SENSOR_WINDOW_NORMALIZER_ASSERT_SVH
`define SENSOR_WINDOW_NORMALIZER_ASSERT_SVH

// Same-cycle implication, disabled while reset is held
`define SWN_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("sensor_window_normalizer: same-cycle check failed");

// Next-cycle implication, disabled while reset is held
`define SWN_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("sensor_window_normalizer: next-cycle check failed");

`endif

[design/swn_pkg.sv]
package swn_pkg;

    localparam int CHANNELS    = 6;
    localparam int IN_BITS     = 10;
    localparam int SAMPLE_BITS = 10;
    localparam int LEVEL_BITS  = 8;
    localparam int SLOT_BITS   = 4;
    localparam int SCAN_BITS   = 16;
    localparam int PERCENT     = 100;
    localparam int LEVEL_MAX   = 255;

    localparam logic [SCAN_BITS-1:0] SCAN_RESET = 16'd1000;

    // Command from the control to every lane
    typedef struct packed {
        logic                   start;
        logic                   compute;
        logic                   seed;
        logic [SAMPLE_BITS-1:0] sample;
        logic [SLOT_BITS-1:0]   wr_slot;
        logic [SLOT_BITS-1:0]   rd_slot;
    } lane_ctl_t;

    // Status returned by each lane
    typedef struct packed {
        logic                  busy;
        logic [LEVEL_BITS-1:0] level;
    } lane_sts_t;

endpackage

[design/swn_div.sv]
module swn_div #(
    parameter int WIDTH = 17
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [WIDTH-1:0] dividend,
    input  logic [WIDTH-1:0] divisor,
    output logic             busy,
    output logic [WIDTH-1:0] quotient
);

    localparam int CNT_W = $clog2(WIDTH + 1);

    logic [WIDTH-1:0] rem_reg, rem_next;
    logic [WIDTH-1:0] quo_reg, quo_next;
    logic [WIDTH-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [WIDTH:0]   trial;

    // One restoring step: shift in the next dividend bit and try the subtract
    always_comb begin
        trial = {rem_reg, quo_reg[WIDTH-1]};
        if (trial >= {1'b0, den_reg}) begin
            rem_next = WIDTH'(trial - {1'b0, den_reg});
            quo_next = {quo_reg[WIDTH-2:0], 1'b1};
        end else begin
            rem_next = trial[WIDTH-1:0];
            quo_next = {quo_reg[WIDTH-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (start) begin
            cnt_reg <= CNT_W'(WIDTH);
        end else if (cnt_reg != '0) begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
            den_reg <= divisor;
        end else if (cnt_reg != '0) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign busy     = (cnt_reg != '0);
    assign quotient = quo_reg;

endmodule

[design/swn_lane.sv]
module swn_lane #(
    parameter int WINDOW = 10
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  swn_pkg::lane_ctl_t ctl,
    output swn_pkg::lane_sts_t sts
);

    localparam int SB     = swn_pkg::SAMPLE_BITS;
    localparam int WSUM   = WINDOW * (WINDOW + 1) / 2;
    localparam int SLOT_W = $clog2(WINDOW);
    localparam int WGT_W  = $clog2(WINDOW + 1);
    localparam int ACC_W  = $clog2(((1 << SB) - 1) * WSUM + 1);
    localparam int PROD_W = $clog2(((1 << SB) - 1) * swn_pkg::PERCENT + 1);
    localparam int DIV_W  = PROD_W;
    localparam int LB     = swn_pkg::LEVEL_BITS;
    // Reciprocal of the weight sum, exact for every accumulator value
    localparam int     WSUM_W = $clog2(WSUM);
    localparam int     RSH    = ACC_W + WSUM_W;
    localparam int     RPW    = RSH + SB;
    localparam longint RECIP  = ((longint'(1) << RSH) + longint'(WSUM) - 1) / longint'(WSUM);

    typedef enum logic [2:0] {
        L_IDLE, L_ACC, L_AVG, L_UPD, L_LVL_GO, L_LVL_WAIT
    } lane_state_t;

    lane_state_t       state_reg;
    logic [SB-1:0]     ring_reg [WINDOW];
    logic [SLOT_W-1:0] rd_reg;
    logic [WGT_W-1:0]  wgt_reg;
    logic [ACC_W-1:0]  acc_reg;
    logic [SB-1:0]     avg_reg;
    logic [SB-1:0]     min_reg, min_next;
    logic [SB-1:0]     max_reg, max_next;
    logic              seed_reg;
    logic [LB-1:0]     level_reg;

    logic [SB+WGT_W-1:0] prod;
    logic [RPW-1:0]      avg_prod;
    logic [PROD_W-1:0]   num;
    logic                div_start;
    logic [DIV_W-1:0]    div_a;
    logic [DIV_W-1:0]    div_b;
    logic                div_busy;
    logic [DIV_W-1:0]    div_q;

    // Weighted tap: oldest sample first with weight one
    assign prod = (SB+WGT_W)'(ring_reg[rd_reg]) * (SB+WGT_W)'(wgt_reg);
    assign num  = PROD_W'(avg_reg - min_reg) * PROD_W'(swn_pkg::PERCENT);

    // Divide the weighted sum by the weight sum through its reciprocal
    assign avg_prod = RPW'(acc_reg) * RPW'(RECIP);

    // Seed or widen the tracked range
    always_comb begin
        min_next = min_reg;
        max_next = max_reg;
        priority if (seed_reg) begin
            min_next = avg_reg;
            max_next = avg_reg;
        end else if (avg_reg > max_reg) begin
            max_next = avg_reg;
        end else if (avg_reg < min_reg) begin
            min_next = avg_reg;
        end
    end

    // Feed the range divider
    assign div_start = (state_reg == L_LVL_GO);
    assign div_a     = DIV_W'(num);
    assign div_b     = DIV_W'(max_reg - min_reg);

    swn_div #(.WIDTH(DIV_W)) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_a),
        .divisor  (div_b),
        .busy     (div_busy),
        .quotient (div_q)
    );

    // Store the new sample in the ring
    always_ff @(posedge aclk) begin
        if (ctl.start) begin
            ring_reg[ctl.wr_slot[SLOT_W-1:0]] <= ctl.sample;
        end
    end

    // Sequence one transaction through accumulate, average and level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= L_IDLE;
            min_reg   <= '0;
            max_reg   <= '0;
            level_reg <= '0;
        end else begin
            unique case (state_reg)
                L_IDLE: begin
                    if (ctl.start) begin
                        level_reg <= '0;
                        seed_reg  <= ctl.seed;
                        rd_reg    <= ctl.rd_slot[SLOT_W-1:0];
                        wgt_reg   <= WGT_W'(1);
                        acc_reg   <= '0;
                        if (ctl.compute) begin
                            state_reg <= L_ACC;
                        end
                    end
                end
                L_ACC: begin
                    acc_reg <= acc_reg + ACC_W'(prod);
                    wgt_reg <= wgt_reg + 1'b1;
                    rd_reg  <= (rd_reg == SLOT_W'(WINDOW - 1)) ? '0 : rd_reg + 1'b1;
                    if (wgt_reg == WGT_W'(WINDOW)) begin
                        state_reg <= L_AVG;
                    end
                end
                L_AVG: begin
                    avg_reg   <= avg_prod[RSH +: SB];
                    state_reg <= L_UPD;
                end
                L_UPD: begin
                    min_reg <= min_next;
                    max_reg <= max_next;
                    if (max_next > min_next && avg_reg >= min_next) begin
                        state_reg <= L_LVL_GO;
                    end else begin
                        state_reg <= L_IDLE;
                    end
                end
                L_LVL_GO: begin
                    state_reg <= L_LVL_WAIT;
                end
                L_LVL_WAIT: begin
                    if (!div_busy) begin
                        level_reg <= (div_q > DIV_W'(swn_pkg::LEVEL_MAX)) ?
                                     LB'(swn_pkg::LEVEL_MAX) : div_q[LB-1:0];
                        state_reg <= L_IDLE;
                    end
                end
                default: begin
                    state_reg <= L_IDLE;
                end
            endcase
        end
    end

    assign sts.busy  = (state_reg != L_IDLE);
    assign sts.level = level_reg;

endmodule

[design/sensor_window_normalizer.sv]
// Sensor window normaliser: one transaction carries one sample per channel; six lanes
// run side by side, each keeping a WINDOW-deep ring, a linearly weighted average (newest
// weight WINDOW, oldest weight 1) and a tracked min/max, and the merge stage registers
// the levels (avg-min)*100/(max-min), clamped to 255. While the window is still filling, an
// input is only written into the ring; from the input that fills it on, each lane runs the
// multiply-accumulate over the ring, a reciprocal multiplication by the weight sum and the
// 17-bit bit-serial divider for the range, skipped when the tracked range is zero. The next
// input is taken while the previous result waits in the output register. A configuration
// write holds off the input for that cycle. No clearing pass after reset.
module sensor_window_normalizer #(
    parameter int WINDOW = 10
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [15:0] cfg_data,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [9:0] s_sample_ch0,
    input  logic [9:0] s_sample_ch1,
    input  logic [9:0] s_sample_ch2,
    input  logic [9:0] s_sample_ch3,
    input  logic [9:0] s_sample_ch4,
    input  logic [9:0] s_sample_ch5,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_level_ch0,
    output logic [7:0] m_level_ch1,
    output logic [7:0] m_level_ch2,
    output logic [7:0] m_level_ch3,
    output logic [7:0] m_level_ch4,
    output logic [7:0] m_level_ch5,
    output logic       m_window_ready,
    output logic       m_scan_done
);

    localparam int NCH    = swn_pkg::CHANNELS;
    localparam int SB     = swn_pkg::SAMPLE_BITS;
    localparam int LB     = swn_pkg::LEVEL_BITS;
    localparam int SCB    = swn_pkg::SCAN_BITS;
    localparam int SLOT_W = $clog2(WINDOW);
    localparam int FILL_W = $clog2(WINDOW + 1);

    typedef enum logic [1:0] {T_IDLE, T_RUN, T_OUT} top_state_t;

    top_state_t         state_reg;
    logic [SLOT_W-1:0]  slot_reg;
    logic [FILL_W-1:0]  fill_reg;
    logic [SCB-1:0]     scan_left_reg, scan_left_next;
    logic               done_reg, done_next;
    logic               ready_hold_reg;
    logic               m_valid_reg;
    logic [LB-1:0]      level_reg [NCH];
    logic               win_out_reg;
    logic               done_out_reg;

    logic                 in_acc;
    logic                 was_ready;
    logic                 now_ready;
    logic [SLOT_W-1:0]    rd_slot;
    logic [SB-1:0]        samples [NCH];
    swn_pkg::lane_ctl_t   ctl [NCH];
    swn_pkg::lane_sts_t   sts [NCH];
    logic                 any_busy;

    assign samples[0] = s_sample_ch0[SB-1:0];
    assign samples[1] = s_sample_ch1[SB-1:0];
    assign samples[2] = s_sample_ch2[SB-1:0];
    assign samples[3] = s_sample_ch3[SB-1:0];
    assign samples[4] = s_sample_ch4[SB-1:0];
    assign samples[5] = s_sample_ch5[SB-1:0];

    assign s_ready   = (state_reg == T_IDLE) && !cfg_valid;
    assign cfg_ready = (state_reg == T_IDLE);
    assign in_acc    = s_valid && s_ready;
    assign was_ready = (fill_reg == FILL_W'(WINDOW));
    assign now_ready = was_ready || (fill_reg == FILL_W'(WINDOW - 1));
    assign rd_slot   = (slot_reg == SLOT_W'(WINDOW - 1)) ? '0 : slot_reg + 1'b1;

    // Calibration countdown, run on every tick after the filling tick
    always_comb begin
        scan_left_next = scan_left_reg;
        done_next      = done_reg;
        if (was_ready) begin
            if (scan_left_reg != '0) begin
                scan_left_next = scan_left_reg - 1'b1;
            end
            if (scan_left_next == '0) begin
                done_next = 1'b1;
            end
        end
    end

    // Issue the transaction to all lanes
    generate
        for (genvar ch = 0; ch < NCH; ch++) begin : g_lane
            assign ctl[ch].start   = in_acc;
            assign ctl[ch].compute = now_ready;
            assign ctl[ch].seed    = !was_ready;
            assign ctl[ch].sample  = samples[ch];
            assign ctl[ch].wr_slot = swn_pkg::SLOT_BITS'(slot_reg);
            assign ctl[ch].rd_slot = swn_pkg::SLOT_BITS'(rd_slot);

            swn_lane #(.WINDOW(WINDOW)) u_lane (
                .aclk    (aclk),
                .aresetn (aresetn),
                .ctl     (ctl[ch]),
                .sts     (sts[ch])
            );
        end
    endgenerate

    always_comb begin
        any_busy = 1'b0;
        for (int ch = 0; ch < NCH; ch++) begin
            any_busy = any_busy | sts[ch].busy;
        end
    end

    // Control, countdown and merge into the output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= T_IDLE;
            slot_reg      <= '0;
            fill_reg      <= '0;
            scan_left_reg <= swn_pkg::SCAN_RESET;
            done_reg      <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            // Drop a taken result unless a new one replaces it
            if (m_valid_reg && m_ready && state_reg != T_OUT) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                T_IDLE: begin
                    if (cfg_valid) begin
                        scan_left_reg <= cfg_data;
                        done_reg      <= 1'b0;
                    end else if (in_acc) begin
                        slot_reg       <= rd_slot;
                        fill_reg       <= was_ready ? fill_reg : fill_reg + 1'b1;
                        scan_left_reg  <= scan_left_next;
                        done_reg       <= done_next;
                        ready_hold_reg <= now_ready;
                        state_reg      <= T_RUN;
                    end
                end
                T_RUN: begin
                    if (!any_busy) begin
                        state_reg <= T_OUT;
                    end
                end
                T_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg  <= 1'b1;
                        win_out_reg  <= ready_hold_reg;
                        done_out_reg <= done_reg;
                        for (int ch = 0; ch < NCH; ch++) begin
                            level_reg[ch] <= sts[ch].level;
                        end
                        state_reg <= T_IDLE;
                    end
                end
                default: begin
                    state_reg <= T_IDLE;
                end
            endcase
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_level_ch0    = level_reg[0];
    assign m_level_ch1    = level_reg[1];
    assign m_level_ch2    = level_reg[2];
    assign m_level_ch3    = level_reg[3];
    assign m_level_ch4    = level_reg[4];
    assign m_level_ch5    = level_reg[5];
    assign m_window_ready = win_out_reg;
    assign m_scan_done    = done_out_reg;

endmodule

[design/swn_checker.sv]
`include "sensor_window_normalizer_assert.svh"

module swn_props (
    input logic       aclk,
    input logic       aresetn,
    input logic       cfg_valid,
    input logic       cfg_ready,
    input logic       s_valid,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_level_ch0,
    input logic [7:0] m_level_ch1,
    input logic [7:0] m_level_ch2,
    input logic [7:0] m_level_ch3,
    input logic [7:0] m_level_ch4,
    input logic [7:0] m_level_ch5,
    input logic       m_window_ready,
    input logic       m_scan_done
);

    // Hold off new input while a transaction is being worked on
    `SWN_ASSERT_NEXT(a_busy_after_accept, s_valid && s_ready, !s_ready)

    // Hold off new input while the register is written
    `SWN_ASSERT_NOW(a_cfg_excl, cfg_valid && cfg_ready, !s_ready)

    // Hold a stalled result
    `SWN_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_level_ch0))

    // Drop every level to zero while the window is still filling
    `SWN_ASSERT_NOW(a_fill_zero, m_valid && !m_window_ready,
        m_level_ch0 == 8'd0 && m_level_ch1 == 8'd0 && m_level_ch2 == 8'd0 &&
        m_level_ch3 == 8'd0 && m_level_ch4 == 8'd0 && m_level_ch5 == 8'd0)

    // Finish the scan only after the window has filled
    `SWN_ASSERT_NOW(a_done_needs_window, m_valid && m_scan_done, m_window_ready)

endmodule

bind sensor_window_normalizer swn_props u_swn_props (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_level_ch0    (m_level_ch0),
    .m_level_ch1    (m_level_ch1),
    .m_level_ch2    (m_level_ch2),
    .m_level_ch3    (m_level_ch3),
    .m_level_ch4    (m_level_ch4),
    .m_level_ch5    (m_level_ch5),
    .m_window_ready (m_window_ready),
    .m_scan_done    (m_scan_done)
);

[bench/swn_checker.sv]
`timescale 1ns / 100ps

module swn_checker (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_valid,
    input  logic       cfg_ready,
    input  logic [15:0] cfg_data,
    input  logic       s_valid,
    input  logic       s_ready,
    input  logic [9:0] s_sample_ch0,
    input  logic [9:0] s_sample_ch1,
    input  logic [9:0] s_sample_ch2,
    input  logic [9:0] s_sample_ch3,
    input  logic [9:0] s_sample_ch4,
    input  logic [9:0] s_sample_ch5,
    input  logic       m_valid,
    input  logic       m_ready,
    input  logic [7:0] m_level_ch0,
    input  logic [7:0] m_level_ch1,
    input  logic [7:0] m_level_ch2,
    input  logic [7:0] m_level_ch3,
    input  logic [7:0] m_level_ch4,
    input  logic [7:0] m_level_ch5,
    input  logic       m_window_ready,
    input  logic       m_scan_done,
    output int         fail_count,
    output int         pending_levels
);

    localparam int NCH = swn_pkg::CHANNELS;
    localparam int SB  = swn_pkg::SAMPLE_BITS;
    localparam int IB  = swn_pkg::IN_BITS;
    localparam int LB  = swn_pkg::LEVEL_BITS;
    localparam int SCB = swn_pkg::SCAN_BITS;
    localparam int RING_DEPTH = 10;
    localparam int WEIGHT_TOTAL = RING_DEPTH * (RING_DEPTH + 1) / 2;

    typedef struct packed {
        logic [NCH-1:0][LB-1:0] level;
        logic                   window_ready;
        logic                   scan_done;
    } level_set_t;

    logic [SB-1:0]  ring [NCH][RING_DEPTH];
    int unsigned    slot;
    int unsigned    filled;
    logic [SB-1:0]  lo [NCH];
    logic [SB-1:0]  hi [NCH];
    logic [SCB-1:0] scan_remaining;
    logic           calib_done;
    level_set_t     expected_levels [$];

    task automatic report(input string what, input int got, input int want);
        $display("%0t mismatch %s: got %0d want %0d", $realtime, what, got, want);
        fail_count++;
    endtask

    // Advance the normaliser state by one tick and queue its result
    function automatic void normalise(input logic [NCH-1:0][IB-1:0] smp);
        level_set_t  r;
        logic        was_full;
        int unsigned acc;
        int unsigned avg;
        int unsigned lvl;
        was_full = (filled >= RING_DEPTH);
        for (int c = 0; c < NCH; c++)
            ring[c][slot] = smp[c][SB-1:0];
        slot = (slot + 1) % RING_DEPTH;
        if (filled < RING_DEPTH)
            filled++;
        r = '0;
        r.window_ready = (filled >= RING_DEPTH);
        for (int c = 0; c < NCH; c++) begin
            lvl = 0;
            if (r.window_ready) begin
                acc = 0;
                // slot now points at the oldest sample, weight 1
                for (int k = 0; k < RING_DEPTH; k++)
                    acc += ring[c][(slot + k) % RING_DEPTH] * (k + 1);
                avg = acc / WEIGHT_TOTAL;
                if (!was_full) begin
                    lo[c] = SB'(avg);
                    hi[c] = SB'(avg);
                end else if (avg > hi[c]) begin
                    hi[c] = SB'(avg);
                end else if (avg < lo[c]) begin
                    lo[c] = SB'(avg);
                end
                if (hi[c] > lo[c] && avg >= lo[c]) begin
                    lvl = (avg - lo[c]) * swn_pkg::PERCENT / (hi[c] - lo[c]);
                    if (lvl > swn_pkg::LEVEL_MAX)
                        lvl = swn_pkg::LEVEL_MAX;
                end
            end
            r.level[c] = lvl[LB-1:0];
        end
        if (was_full) begin
            if (scan_remaining > 0)
                scan_remaining--;
            if (scan_remaining == 0)
                calib_done = 1'b1;
        end
        r.scan_done = calib_done;
        expected_levels.push_back(r);
    endfunction

    // Track transactions on all six channels
    always @(posedge aclk) begin
        level_set_t exp_r;
        level_set_t got_r;
        if (!aresetn) begin
            for (int c = 0; c < NCH; c++) begin
                for (int k = 0; k < RING_DEPTH; k++)
                    ring[c][k] = '0;
                lo[c] = '0;
                hi[c] = '0;
            end
            slot = 0;
            filled = 0;
            scan_remaining = swn_pkg::SCAN_RESET;
            calib_done = 1'b0;
            expected_levels.delete();
            fail_count = 0;
            pending_levels = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                scan_remaining = cfg_data;
                calib_done = 1'b0;
            end
            if (m_valid && m_ready) begin
                got_r.level = {m_level_ch5, m_level_ch4, m_level_ch3,
                               m_level_ch2, m_level_ch1, m_level_ch0};
                got_r.window_ready = m_window_ready;
                got_r.scan_done = m_scan_done;
                if (expected_levels.size() == 0) begin
                    $display("%0t unexpected result transaction", $realtime);
                    fail_count++;
                end else begin
                    exp_r = expected_levels.pop_front();
                    for (int c = 0; c < NCH; c++)
                        if (got_r.level[c] !== exp_r.level[c])
                            report($sformatf("level_ch%0d", c), int'(got_r.level[c]),
                                   int'(exp_r.level[c]));
                    if (got_r.window_ready !== exp_r.window_ready)
                        report("window_ready", int'(got_r.window_ready),
                               int'(exp_r.window_ready));
                    if (got_r.scan_done !== exp_r.scan_done)
                        report("scan_done", int'(got_r.scan_done), int'(exp_r.scan_done));
                end
            end
            if (s_valid && s_ready)
                normalise({s_sample_ch5, s_sample_ch4, s_sample_ch3,
                           s_sample_ch2, s_sample_ch1, s_sample_ch0});
            pending_levels = expected_levels.size();
        end
    end

endmodule

[bench/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;

    localparam int RANDOM_TICKS = 1600;
    localparam int SETTLE_CYCLES = 100;

    logic       aclk;
    logic       aresetn;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [15:0] cfg_data;
    logic       s_valid;
    logic       s_ready;
    logic [9:0] s_smp [swn_pkg::CHANNELS];
    logic       m_valid;
    logic       m_ready;
    logic [7:0] m_lvl [swn_pkg::CHANNELS];
    logic       m_window_ready;
    logic       m_scan_done;
    int         fail_count;
    int         pending_levels;
    logic       stall_free;

    sensor_window_normalizer dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_sample_ch0(s_smp[0]), .s_sample_ch1(s_smp[1]), .s_sample_ch2(s_smp[2]),
        .s_sample_ch3(s_smp[3]), .s_sample_ch4(s_smp[4]), .s_sample_ch5(s_smp[5]),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_level_ch0(m_lvl[0]), .m_level_ch1(m_lvl[1]), .m_level_ch2(m_lvl[2]),
        .m_level_ch3(m_lvl[3]), .m_level_ch4(m_lvl[4]), .m_level_ch5(m_lvl[5]),
        .m_window_ready(m_window_ready), .m_scan_done(m_scan_done)
    );

    swn_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_sample_ch0(s_smp[0]), .s_sample_ch1(s_smp[1]), .s_sample_ch2(s_smp[2]),
        .s_sample_ch3(s_smp[3]), .s_sample_ch4(s_smp[4]), .s_sample_ch5(s_smp[5]),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_level_ch0(m_lvl[0]), .m_level_ch1(m_lvl[1]), .m_level_ch2(m_lvl[2]),
        .m_level_ch3(m_lvl[3]), .m_level_ch4(m_lvl[4]), .m_level_ch5(m_lvl[5]),
        .m_window_ready(m_window_ready), .m_scan_done(m_scan_done),
        .fail_count(fail_count), .pending_levels(pending_levels)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Drop ready for a random number of cycles after each result transaction, unless stall_free is set
    initial begin
        int gap;
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) begin
                gap = stall_free ? 0 : $urandom_range(0, 18);
                if (gap > 0) begin
                    m_ready <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
                m_ready <= 1'b1;
            end else if (aresetn) begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic idle_cycles(input int n);
        repeat (n) @(posedge aclk);
    endtask

    // Send one tick of samples and hold it until accepted
    task automatic send_tick(input logic [9:0] a0, input logic [9:0] a1,
                             input logic [9:0] a2, input logic [9:0] a3,
                             input logic [9:0] a4, input logic [9:0] a5);
        int gap;
        gap = stall_free ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
            s_valid <= 1'b0;
            idle_cycles(gap);
        end
        s_smp[0] <= a0; s_smp[1] <= a1; s_smp[2] <= a2;
        s_smp[3] <= a3; s_smp[4] <= a4; s_smp[5] <= a5;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!(s_valid && s_ready));
    endtask

    task automatic send_uniform(input logic [9:0] v);
        send_tick(v, v, v, v, v, v);
    endtask

    task automatic drain;
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_levels != 0)
            @(posedge aclk);
        idle_cycles(SETTLE_CYCLES);
    endtask

    task automatic write_scan(input logic [15:0] v);
        cfg_data <= v;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
    endtask

    // Random tick: mostly a slow drift around a level, sometimes full-scale noise
    task automatic send_random(inout int base [swn_pkg::CHANNELS]);
        logic [9:0] v [swn_pkg::CHANNELS];
        for (int c = 0; c < swn_pkg::CHANNELS; c++) begin
            if ($urandom_range(0, 9) == 0)
                v[c] = 10'($urandom_range(0, 1023));
            else begin
                base[c] = base[c] + $urandom_range(0, 60) - 30;
                if (base[c] < 0) base[c] = 0;
                if (base[c] > 1023) base[c] = 1023;
                v[c] = 10'(base[c]);
            end
        end
        send_tick(v[0], v[1], v[2], v[3], v[4], v[5]);
    endtask

    initial begin
        int base [swn_pkg::CHANNELS];
        logic [15:0] scan_values [5];
        aresetn = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        s_valid = 1'b0;
        for (int c = 0; c < swn_pkg::CHANNELS; c++) begin
            s_smp[c] = '0;
            base[c] = $urandom_range(0, 1023);
        end
        stall_free = 1'b0;
        idle_cycles(4);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Short scan, then fill the window with full-scale and zero extremes
        write_scan(16'd3);
        for (int i = 0; i < 5; i++)
            send_uniform(10'h3FF);
        for (int i = 0; i < 5; i++)
            send_uniform(10'h000);
        // Zero range while flat, then widening both ways
        send_uniform(10'h000);
        send_tick(10'h3FF, 10'h155, 10'h2AA, 10'h001, 10'h200, 10'h3FE);
        send_tick(10'h3FF, 10'h2AA, 10'h155, 10'h3FF, 10'h100, 10'h000);
        send_uniform(10'h3FF);
        send_uniform(10'h000);
        send_uniform(10'h000);
        // Let the sender wait until every result has come
        drain();

        // Zero scan finishes on the first counted tick
        write_scan(16'd0);
        for (int i = 0; i < 4; i++)
            send_uniform(10'(10'h200 + i));
        drain();

        // Several scan settings including the extremes, with random ticks
        scan_values = '{16'd1, 16'd50, 16'hFFFF, 16'd1000, 16'd400};
        for (int p = 0; p < 5; p++) begin
            write_scan(scan_values[p]);
            stall_free = (p == 3);
            for (int i = 0; i < RANDOM_TICKS / 5; i++)
                send_random(base);
            drain();
        end
        stall_free = 1'b0;

        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // End the run if it hangs
    initial begin
        #20ms;
        $display("Some tests failed");
        $finish;
    end

endmodule
